// ----- hw/rtl/rgb_led_one_wire_serializer_top_assert.svh -----
// Assertion macros for the one-wire RGB LED serializer
`ifndef RGB_LED_ONE_WIRE_SERIALIZER_TOP_ASSERT_SVH
`define RGB_LED_ONE_WIRE_SERIALIZER_TOP_ASSERT_SVH

`ifndef SYNTH

// Check a property on each rising edge, switched off while reset is low
`define RGBLS_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("rgbls assertion failed");

// Check a property on each rising edge, reset included
`define RGBLS_ASSERT(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("rgbls assertion failed");

`else

`define RGBLS_ASSERT_RST(label, clk, rst_n, prop)
`define RGBLS_ASSERT(label, clk, prop)

`endif

`endif

// ----- hw/rtl/rgbls_pkg.sv -----
// Shared types and constants of the one-wire RGB LED serializer
`default_nettype none

package rgbls_pkg;

    // Store size and field widths
    localparam int MAX_LEDS_DEF   = 1024;
    localparam int TICK_W         = 15;
    localparam int LED_CNT_W      = 11;
    localparam int LED_IDX_W      = 10;
    localparam int COLOUR_W       = 8;
    localparam int PIX_W          = 24;
    localparam int BIT_W          = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 8;

    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(PIX_W - 1);

    // Register reset values
    localparam logic [TICK_W-1:0]    ZERO_HIGH_RST = TICK_W'(4);
    localparam logic [TICK_W-1:0]    ZERO_LOW_RST  = TICK_W'(8);
    localparam logic [TICK_W-1:0]    ONE_HIGH_RST  = TICK_W'(8);
    localparam logic [TICK_W-1:0]    ONE_LOW_RST   = TICK_W'(4);
    localparam logic [TICK_W-1:0]    LATCH_RST     = TICK_W'(600);
    localparam logic [LED_CNT_W-1:0] LED_COUNT_RST = '0;

    // Commands carried in s_tuser
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SET     = 2'd1,
        CMD_REFRESH = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    // Line phase of the frame in progress
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } phase_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_HIGH = 3'd0,
        CFG_ZERO_LOW  = 3'd1,
        CFG_ONE_HIGH  = 3'd2,
        CFG_ONE_LOW   = 3'd3,
        CFG_LATCH     = 3'd4,
        CFG_LED_COUNT = 3'd5
    } cfg_idx_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WIPE,
        ST_FETCH,
        ST_LOAD
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept_en;
        logic sweep_en;
        logic sweep_all;
        logic fetch;
        logic load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic start_wipe;
        logic need_fetch;
        logic sweep_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rgb_led_one_wire_serializer_top.sv -----
// Top level of the one-wire RGB LED serializer
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser: cmd; s_tdata: index, r, g, b
//  m_      | out | m_tvalid/m_tready  | m_tdata: line_level, busy_res, rejected
//  cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wdata (15 bits)
//
//  The result of each command transfer lands in the output slot.
//  A tick that moves to a new pixel, and a refresh, block input through the
//  FETCH and LOAD states while the store is read (one read port, registered data).
//  A clear blocks input while it zeroes each LED in the chain, then for the read.
//  After reset a pass over all MAX_LEDS entries zeroes the store; s_tready is low
//  through it. Configuration writes are taken in every cycle.
//  A skid slot lets one transfer in while a result waits on m_tready.
`default_nettype none

module rgb_led_one_wire_serializer_top #(
    parameter int MAX_LEDS = rgbls_pkg::MAX_LEDS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire  [rgbls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [rgbls_pkg::TICK_W-1:0]      cfg_wdata,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // led_index[9:0], red[17:10], green[25:18], blue[33:26], zero pad
    input  wire  [rgbls_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd[1:0]
    input  wire  [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // line_level[0], busy_res[1], rejected[2], zero pad
    output logic [rgbls_pkg::M_TDATA_W-1:0]   m_tdata
);

    rgbls_pkg::ctrl_cmd_t ctl_cmd;
    rgbls_pkg::dp_stat_t  dp_stat;

    // Sequence the store sweeps and reads
    rgbls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .dp_stat (dp_stat),
        .ctl_cmd (ctl_cmd)
    );

    // Hold the store, registers and line timing
    rgbls_dp #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .ctl_cmd   (ctl_cmd),
        .dp_stat   (dp_stat)
    );

`include "rgb_led_one_wire_serializer_top_assert.svh"

    // Every accepted transfer leaves a result behind
    `RGBLS_ASSERT_RST(a_result_follows, aclk, aresetn, (s_tvalid && s_tready) |=> m_tvalid)

    // A pixel fetch blocks the next transfer
    `RGBLS_ASSERT_RST(a_fetch_blocks, aclk, aresetn, (s_tvalid && s_tready && dp_stat.need_fetch) |=> !s_tready)

    // A high line is only reported during a frame
    `RGBLS_ASSERT(a_line_busy, aclk, (m_tvalid && m_tdata[0]) |-> m_tdata[1])

endmodule

`default_nettype wire

// ----- hw/rtl/rgbls_ctrl.sv -----
// Controller state machine of the one-wire RGB LED serializer
`default_nettype none

module rgbls_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  rgbls_pkg::dp_stat_t    dp_stat,
    output rgbls_pkg::ctrl_cmd_t   ctl_cmd
);

    rgbls_pkg::ctrl_state_t state_reg;
    rgbls_pkg::ctrl_state_t state_next;

    // Hold the state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rgbls_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Choose the next state and drive the datapath commands
    always_comb begin
        state_next = state_reg;
        ctl_cmd    = '0;
        case (state_reg)
            rgbls_pkg::ST_INIT: begin
                ctl_cmd.sweep_en  = 1'b1;
                ctl_cmd.sweep_all = 1'b1;
                if (dp_stat.sweep_last) begin
                    state_next = rgbls_pkg::ST_IDLE;
                end
            end
            rgbls_pkg::ST_IDLE: begin
                ctl_cmd.accept_en = 1'b1;
                if (dp_stat.start_wipe) begin
                    state_next = rgbls_pkg::ST_WIPE;
                end else if (dp_stat.need_fetch) begin
                    state_next = rgbls_pkg::ST_FETCH;
                end
            end
            rgbls_pkg::ST_WIPE: begin
                ctl_cmd.sweep_en = 1'b1;
                if (dp_stat.sweep_last) begin
                    state_next = rgbls_pkg::ST_FETCH;
                end
            end
            rgbls_pkg::ST_FETCH: begin
                ctl_cmd.fetch = 1'b1;
                state_next    = rgbls_pkg::ST_LOAD;
            end
            rgbls_pkg::ST_LOAD: begin
                ctl_cmd.load = 1'b1;
                state_next   = rgbls_pkg::ST_IDLE;
            end
            default: begin
                state_next = rgbls_pkg::ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rgbls_dp.sv -----
// Datapath of the one-wire RGB LED serializer: registers, pixel store, bit timing
`default_nettype none

module rgbls_dp #(
    parameter int MAX_LEDS = rgbls_pkg::MAX_LEDS_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_wr_en,
    input  wire  [rgbls_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [rgbls_pkg::TICK_W-1:0]          cfg_wdata,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [rgbls_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire  [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [rgbls_pkg::M_TDATA_W-1:0]       m_tdata,
    input  rgbls_pkg::ctrl_cmd_t                  ctl_cmd,
    output rgbls_pkg::dp_stat_t                   dp_stat
);

    localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W = $clog2(MAX_LEDS + 1);
    localparam int LW    = (CNT_W > rgbls_pkg::LED_CNT_W) ? CNT_W : rgbls_pkg::LED_CNT_W;
    localparam int TW    = rgbls_pkg::TICK_W;
    localparam int PW    = rgbls_pkg::PIX_W;
    localparam int CW    = rgbls_pkg::COLOUR_W;
    localparam int XW    = rgbls_pkg::LED_IDX_W;

    // Configuration registers
    logic [TW-1:0]                   zero_high_reg;
    logic [TW-1:0]                   zero_low_reg;
    logic [TW-1:0]                   one_high_reg;
    logic [TW-1:0]                   one_low_reg;
    logic [TW-1:0]                   latch_reg;
    logic [rgbls_pkg::LED_CNT_W-1:0] led_count_reg;

    // Frame state
    rgbls_pkg::phase_t               phase_reg, phase_next;
    logic [TW-1:0]                   tick_reg, tick_next;
    logic [rgbls_pkg::BIT_W-1:0]     bit_reg, bit_next;
    logic [IDX_W-1:0]                pixel_reg, pixel_next;
    logic [PW-1:0]                   shift_reg, shift_next;
    logic [CNT_W-1:0]                sweep_reg;

    // Pixel store and its registered read
    logic [PW-1:0]                   mem [MAX_LEDS];
    logic [PW-1:0]                   rd_data_reg;
    logic                            mem_we;
    logic [IDX_W-1:0]                mem_addr;
    logic [PW-1:0]                   mem_wdata;

    // Result slot and skid slot
    logic                            main_v_reg, skid_v_reg;
    logic [rgbls_pkg::M_TDATA_W-1:0] main_reg, skid_reg;

    // Item decode
    rgbls_pkg::cmd_t                 cmd;
    logic [XW-1:0]                   in_index;
    logic [CW-1:0]                   in_red, in_green, in_blue;
    logic [LW-1:0]                   led_ext, max_ext, idx_ext;
    logic [CNT_W-1:0]                chain_len;
    logic [CNT_W-1:0]                next_pix;
    logic [CNT_W-1:0]                sweep_limit;
    logic [CNT_W-1:0]                sweep_inc;
    logic                            fire, pop, busy, bit_one, set_we;
    logic [TW-1:0]                   dur;
    logic [TW:0]                     tick_inc;
    logic                            res_line, res_busy, res_rej;
    logic                            need_fetch, start_wipe;
    logic [rgbls_pkg::M_TDATA_W-1:0] result;

    assign cmd      = rgbls_pkg::cmd_t'(s_tuser);
    assign in_index = s_tdata[XW-1:0];
    assign in_red   = s_tdata[XW+CW-1:XW];
    assign in_green = s_tdata[XW+2*CW-1:XW+CW];
    assign in_blue  = s_tdata[XW+3*CW-1:XW+2*CW];

    // Chain length saturates at the store size
    assign led_ext   = LW'(led_count_reg);
    assign max_ext   = LW'(MAX_LEDS);
    assign idx_ext   = LW'(in_index);
    assign chain_len = (led_ext > max_ext) ? max_ext[CNT_W-1:0] : led_ext[CNT_W-1:0];
    assign next_pix  = CNT_W'(pixel_reg) + CNT_W'(1);

    // Handshake
    assign s_tready = ctl_cmd.accept_en & ~skid_v_reg;
    assign fire     = s_tvalid & s_tready;
    assign pop      = main_v_reg & m_tready;
    assign m_tvalid = main_v_reg;
    assign m_tdata  = main_reg;

    // Sweep counter limit and end
    assign sweep_limit        = ctl_cmd.sweep_all ? CNT_W'(MAX_LEDS) : chain_len;
    assign sweep_inc          = sweep_reg + CNT_W'(1);
    assign dp_stat.sweep_last = ctl_cmd.sweep_en & (sweep_inc == sweep_limit);
    assign dp_stat.need_fetch = need_fetch;
    assign dp_stat.start_wipe = start_wipe;

    // Bit timing of the current phase
    assign busy    = (phase_reg != rgbls_pkg::PH_IDLE);
    assign bit_one = shift_reg[PW-1];
    always_comb begin
        case (phase_reg)
            rgbls_pkg::PH_HIGH: dur = bit_one ? one_high_reg : zero_high_reg;
            rgbls_pkg::PH_LOW:  dur = bit_one ? one_low_reg : zero_low_reg;
            default:            dur = latch_reg;
        endcase
    end
    assign tick_inc = {1'b0, tick_reg} + (TW+1)'(1);

    // Work out the result and next frame state of an accepted item
    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        pixel_next = pixel_reg;
        shift_next = ctl_cmd.load ? rd_data_reg : shift_reg;
        res_line   = busy && (phase_reg == rgbls_pkg::PH_HIGH);
        res_busy   = busy;
        res_rej    = 1'b0;
        set_we     = 1'b0;
        need_fetch = 1'b0;
        start_wipe = 1'b0;
        if (fire) begin
            if (cmd == rgbls_pkg::CMD_TICK) begin
                if (busy) begin
                    if (tick_inc < {1'b0, dur}) begin
                        tick_next = tick_inc[TW-1:0];
                    end else begin
                        tick_next = '0;
                        case (phase_reg)
                            rgbls_pkg::PH_HIGH: begin
                                phase_next = rgbls_pkg::PH_LOW;
                            end
                            rgbls_pkg::PH_LOW: begin
                                if (bit_reg != rgbls_pkg::BIT_LAST) begin
                                    bit_next   = bit_reg + 1'b1;
                                    shift_next = {shift_reg[PW-2:0], 1'b0};
                                    phase_next = rgbls_pkg::PH_HIGH;
                                end else begin
                                    bit_next = '0;
                                    if (next_pix >= chain_len) begin
                                        pixel_next = '0;
                                        phase_next = (latch_reg == '0) ?
                                            rgbls_pkg::PH_IDLE : rgbls_pkg::PH_LATCH;
                                    end else begin
                                        pixel_next = next_pix[IDX_W-1:0];
                                        phase_next = rgbls_pkg::PH_HIGH;
                                        need_fetch = 1'b1;
                                    end
                                end
                            end
                            default: begin
                                phase_next = rgbls_pkg::PH_IDLE;
                                pixel_next = '0;
                                bit_next   = '0;
                            end
                        endcase
                    end
                end
            end else if (busy) begin
                res_rej = 1'b1;
            end else if (cmd == rgbls_pkg::CMD_SET) begin
                if (idx_ext >= LW'(chain_len)) begin
                    res_rej = 1'b1;
                end else begin
                    set_we = 1'b1;
                end
            end else if (chain_len != '0) begin
                // Start a frame; a clear wipes the chain first
                phase_next = rgbls_pkg::PH_HIGH;
                pixel_next = '0;
                bit_next   = '0;
                tick_next  = '0;
                res_busy   = 1'b1;
                if (cmd == rgbls_pkg::CMD_CLEAR) begin
                    start_wipe = 1'b1;
                end else begin
                    need_fetch = 1'b1;
                end
            end
        end
    end

    assign result = {{(rgbls_pkg::M_TDATA_W - 3){1'b0}}, res_rej, res_busy, res_line};

    // Store write port: sweep zeroes, set pixel writes GRB
    assign mem_we    = ctl_cmd.sweep_en | set_we;
    assign mem_addr  = ctl_cmd.sweep_en ? sweep_reg[IDX_W-1:0] : idx_ext[IDX_W-1:0];
    assign mem_wdata = ctl_cmd.sweep_en ? '0 : {in_green, in_red, in_blue};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (ctl_cmd.fetch) begin
            rd_data_reg <= mem[pixel_reg];
        end
    end

    // Advance frame state and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rgbls_pkg::PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            pixel_reg <= '0;
            shift_reg <= '0;
            sweep_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            pixel_reg <= pixel_next;
            shift_reg <= shift_next;
            if (dp_stat.sweep_last) begin
                sweep_reg <= '0;
            end else if (ctl_cmd.sweep_en) begin
                sweep_reg <= sweep_inc;
            end
        end
    end

    // Take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_high_reg <= rgbls_pkg::ZERO_HIGH_RST;
            zero_low_reg  <= rgbls_pkg::ZERO_LOW_RST;
            one_high_reg  <= rgbls_pkg::ONE_HIGH_RST;
            one_low_reg   <= rgbls_pkg::ONE_LOW_RST;
            latch_reg     <= rgbls_pkg::LATCH_RST;
            led_count_reg <= rgbls_pkg::LED_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (rgbls_pkg::cfg_idx_t'(cfg_index))
                rgbls_pkg::CFG_ZERO_HIGH: zero_high_reg <= cfg_wdata;
                rgbls_pkg::CFG_ZERO_LOW:  zero_low_reg  <= cfg_wdata;
                rgbls_pkg::CFG_ONE_HIGH:  one_high_reg  <= cfg_wdata;
                rgbls_pkg::CFG_ONE_LOW:   one_low_reg   <= cfg_wdata;
                rgbls_pkg::CFG_LATCH:     latch_reg     <= cfg_wdata;
                rgbls_pkg::CFG_LED_COUNT:
                    led_count_reg <= cfg_wdata[rgbls_pkg::LED_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Result slot with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (fire && (!main_v_reg || pop)) begin
                main_v_reg <= 1'b1;
            end else if (pop) begin
                main_v_reg <= skid_v_reg;
            end
            if (pop) begin
                skid_v_reg <= 1'b0;
            end else if (fire && main_v_reg) begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && skid_v_reg) begin
            main_reg <= skid_reg;
        end else if (fire && (!main_v_reg || pop)) begin
            main_reg <= result;
        end
        if (fire && main_v_reg && !pop) begin
            skid_reg <= result;
        end
    end

endmodule

`default_nettype wire
